>>> design/psdm_pkg.sv
// types, register codes and constants shared by the sine duty pwm modulator
`default_nettype none
package psdm_pkg;

   localparam int COUNT_WIDTH = 24;
   localparam int FIELD_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int PROD_WIDTH = FIELD_WIDTH + COUNT_WIDTH;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [FIELD_WIDTH-1:0] field_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PERIOD     = 3'd0,
      REG_DUTY       = 3'd1,
      REG_MOD_ENABLE = 3'd2,
      REG_MIN_DUTY   = 3'd3,
      REG_MAX_DUTY   = 3'd4,
      REG_MOD_STEP   = 3'd5
   } csr_index_type;

   localparam logic OP_TICK        = 1'b0;
   localparam logic OP_TABLE_WRITE = 1'b1;

   localparam count_type PERIOD_RESET   = count_type'(1000);
   localparam count_type DUTY_RESET     = count_type'(500);
   localparam logic      MOD_EN_RESET   = 1'b0;
   localparam count_type MIN_DUTY_RESET = count_type'(0);
   localparam count_type MAX_DUTY_RESET = count_type'(1000);
   localparam count_type MOD_STEP_RESET = count_type'(1);

   // floor(x / 255) = (x * SPAN_RECIP) >> SPAN_SHIFT for any 32-bit x
   localparam logic [PROD_WIDTH-1:0] SPAN_RECIP = 32'h8080_8081;
   localparam int SPAN_SHIFT = 39;

   typedef struct packed {
      logic      operation;
      logic      running;
      field_type table_index;
      field_type table_value;
   } req_word_type;

   typedef struct packed {
      logic      pulse_out;
      field_type wave_position;
   } rsp_word_type;

   typedef struct packed {
      count_type period_ticks;
      count_type duty_ticks;
      logic      mod_enable;
      count_type min_duty_ticks;
      count_type max_duty_ticks;
      count_type mod_step_ticks;
   } csr_set_type;

   typedef struct packed {
      logic      tick;
      logic      period_start;
      logic      running;
      field_type wave_position;
   } tick_info_type;

endpackage
`default_nettype wire

>>> design/psdm_wave_table.sv
// sine table memory, one write port and one registered read port
`default_nettype none
module psdm_wave_table #(
   parameter int TABLE_SIZE = 256
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
   input  wire psdm_pkg::field_type           wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
   output      psdm_pkg::field_type           rd_data_ff
);
   import psdm_pkg::*;

   field_type sine_mem [TABLE_SIZE];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sine_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= sine_mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> design/psdm_timebase.sv
// period counter, modulation divider and table position, first pipeline stage
`default_nettype none
module psdm_timebase #(
   parameter int TABLE_SIZE = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic                          load,
   input  wire psdm_pkg::req_word_type        req_word,
   input  wire psdm_pkg::csr_set_type         csr,
   output      psdm_pkg::tick_info_type       info_ff,
   output      logic                          wr_en,
   output      logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
   output      logic [$clog2(TABLE_SIZE)-1:0] rd_addr
);
   import psdm_pkg::*;

   localparam int AW = $clog2(TABLE_SIZE);
   localparam logic [AW-1:0] LAST_INDEX = AW'(TABLE_SIZE - 1);
   localparam logic [FIELD_WIDTH:0] TABLE_LIMIT = (FIELD_WIDTH + 1)'(TABLE_SIZE);

   count_type     period_count_ff, period_count_in;
   count_type     mod_divider_ff, mod_divider_in;
   logic [AW-1:0] wave_index_ff, wave_index_in;
   tick_info_type info_in;
   logic          tick;

   always_comb begin
      tick = accept && (req_word.operation == OP_TICK);
      period_count_in = period_count_ff;
      mod_divider_in = mod_divider_ff;
      wave_index_in = wave_index_ff;
      if (tick) begin
         if (period_count_ff <= count_type'(1)) begin
            period_count_in = csr.period_ticks;
         end else begin
            period_count_in = period_count_ff - count_type'(1);
         end
         if (csr.mod_enable) begin
            if (mod_divider_ff <= count_type'(1)) begin
               mod_divider_in = csr.mod_step_ticks;
               wave_index_in = (wave_index_ff == LAST_INDEX) ? '0 : wave_index_ff + 1'b1;
            end else begin
               mod_divider_in = mod_divider_ff - count_type'(1);
            end
         end
      end
      info_in.tick = (req_word.operation == OP_TICK);
      info_in.period_start = (period_count_ff == csr.period_ticks);
      info_in.running = req_word.running;
      info_in.wave_position = field_type'(wave_index_in);
   end

   assign rd_addr = wave_index_ff;
   assign wr_en = accept && (req_word.operation == OP_TABLE_WRITE)
                  && ({1'b0, req_word.table_index} < TABLE_LIMIT);
   assign wr_addr = req_word.table_index[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff <= PERIOD_RESET;
         mod_divider_ff <= MOD_STEP_RESET;
         wave_index_ff <= '0;
      end else begin
         period_count_ff <= period_count_in;
         mod_divider_ff <= mod_divider_in;
         wave_index_ff <= wave_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         info_ff <= info_in;
      end
   end

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      wave_index_ff <= LAST_INDEX)
      else $error("table position beyond table size");

endmodule
`default_nettype wire

>>> design/psdm_duty_scaler.sv
// maps a table entry onto the min..max duty range over two registered stages
`default_nettype none
module psdm_duty_scaler (
   input  wire logic                  clock,
   input  wire logic                  load_mul,
   input  wire logic                  load_div,
   input  wire psdm_pkg::field_type   entry,
   input  wire psdm_pkg::csr_set_type csr,
   output      psdm_pkg::count_type   scaled
);
   import psdm_pkg::*;

   logic [PROD_WIDTH-1:0]   prod_ff, prod_in;
   logic [2*PROD_WIDTH-1:0] recip_prod;
   count_type               quot_ff, quot_in;
   count_type               span;
   logic                    neg_mul_ff, neg_div_ff, neg;

   always_comb begin
      neg = (csr.max_duty_ticks < csr.min_duty_ticks);
      span = neg ? csr.min_duty_ticks - csr.max_duty_ticks
                 : csr.max_duty_ticks - csr.min_duty_ticks;
      prod_in = PROD_WIDTH'(entry) * PROD_WIDTH'(span);
      recip_prod = {PROD_WIDTH'(0), prod_ff} * {PROD_WIDTH'(0), SPAN_RECIP};
      quot_in = recip_prod[SPAN_SHIFT +: COUNT_WIDTH];
      scaled = neg_div_ff ? csr.min_duty_ticks - quot_ff : csr.min_duty_ticks + quot_ff;
   end

   always_ff @(posedge clock) begin
      if (load_mul) begin
         prod_ff <= prod_in;
         neg_mul_ff <= neg;
      end
      if (load_div) begin
         quot_ff <= quot_in;
         neg_div_ff <= neg_mul_ff;
      end
   end

endmodule
`default_nettype wire

>>> design/psdm_pulse_gen.sv
// duty countdown, pin level and result word register
`default_nettype none
module psdm_pulse_gen (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire psdm_pkg::tick_info_type info,
   input  wire psdm_pkg::count_type     scaled,
   input  wire psdm_pkg::csr_set_type   csr,
   input  wire logic                    rsp_stall,
   output      logic                    out_ready,
   output      logic                    rsp_valid_ff,
   output      psdm_pkg::rsp_word_type  rsp_word_ff
);
   import psdm_pkg::*;

   count_type    duty_count_ff, duty_count_in;
   logic         duty_done_ff, duty_done_in;
   logic         pin_ff, pin_in;
   logic         update;
   rsp_word_type rsp_word_in;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign update = out_ready && in_valid;

   always_comb begin
      duty_count_in = duty_count_ff;
      duty_done_in = duty_done_ff;
      pin_in = pin_ff;
      if (update && info.tick) begin
         if (info.period_start) begin
            duty_count_in = csr.mod_enable ? scaled : csr.duty_ticks;
            duty_done_in = 1'b0;
            if (info.running) begin
               pin_in = 1'b1;
            end
         end
         if (!duty_done_in) begin
            if (duty_count_in == '0) begin
               pin_in = 1'b0;
               duty_done_in = 1'b1;
            end else begin
               duty_count_in = duty_count_in - count_type'(1);
            end
         end
      end
      rsp_word_in.pulse_out = pin_in;
      rsp_word_in.wave_position = info.wave_position;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_count_ff <= DUTY_RESET;
         duty_done_ff <= 1'b0;
         pin_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         duty_count_ff <= duty_count_in;
         duty_done_ff <= duty_done_in;
         pin_ff <= pin_in;
         if (out_ready) begin
            rsp_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   a_done_means_low: assert property (@(posedge clock) disable iff (reset)
      duty_done_ff |-> !pin_ff)
      else $error("pin high after duty countdown finished");

   a_write_keeps_pin: assert property (@(posedge clock) disable iff (reset)
      (update && !info.tick) |=> (pin_ff == $past(pin_ff)))
      else $error("table write changed pin level");

endmodule
`default_nettype wire

>>> design/pwm_sine_duty_modulator_unit.sv
// top level of the sine duty pwm modulator: registers, pipeline control, units
//
//   port group   dir   handshake          word
//   req_         in    valid / stall      operation, running, table_index, table_value
//   rsp_         out   valid / stall      pulse_out, wave_position
//   csr_         in    valid / ready      index, data
//
// one word in per clock while req_stall is low; its result word follows it through the stages
// stage one steps the counters and reads the sine table, two multiplies,
// three scales by 1/255, four runs the duty countdown into the result register
// reset is synchronous and active high; the sine table is not cleared
// a stalled result holds the pipeline only once every stage is full
`default_nettype none
module pwm_sine_duty_modulator_unit #(
   parameter int TABLE_SIZE = 256
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire psdm_pkg::req_word_type                req_word,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      psdm_pkg::rsp_word_type                rsp_word,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [psdm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire psdm_pkg::count_type                   csr_data
);
   import psdm_pkg::*;

   localparam int AW = $clog2(TABLE_SIZE);

   csr_set_type   csr_ff;
   logic          v1_ff, v2_ff, v3_ff;
   logic          en1, en2, en3, out_ready;
   logic          accept;
   tick_info_type info1, info2_ff, info3_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   field_type     entry;
   count_type     scaled;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.period_ticks <= PERIOD_RESET;
         csr_ff.duty_ticks <= DUTY_RESET;
         csr_ff.mod_enable <= MOD_EN_RESET;
         csr_ff.min_duty_ticks <= MIN_DUTY_RESET;
         csr_ff.max_duty_ticks <= MAX_DUTY_RESET;
         csr_ff.mod_step_ticks <= MOD_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PERIOD: begin
               csr_ff.period_ticks <= csr_data;
            end
            REG_DUTY: begin
               csr_ff.duty_ticks <= csr_data;
            end
            REG_MOD_ENABLE: begin
               csr_ff.mod_enable <= csr_data[0];
            end
            REG_MIN_DUTY: begin
               csr_ff.min_duty_ticks <= csr_data;
            end
            REG_MAX_DUTY: begin
               csr_ff.max_duty_ticks <= csr_data;
            end
            REG_MOD_STEP: begin
               csr_ff.mod_step_ticks <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign en3 = !v3_ff || out_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;
   assign accept = req_valid && en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         info2_ff <= info1;
      end
      if (en3) begin
         info3_ff <= info2_ff;
      end
   end

   psdm_timebase #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_timebase (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .load     (en1),
      .req_word (req_word),
      .csr      (csr_ff),
      .info_ff  (info1),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .rd_addr  (rd_addr)
   );

   psdm_wave_table #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_wave_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (req_word.table_value),
      .rd_en      (en1),
      .rd_addr    (rd_addr),
      .rd_data_ff (entry)
   );

   psdm_duty_scaler u_duty_scaler (
      .clock    (clock),
      .load_mul (en2),
      .load_div (en3),
      .entry    (entry),
      .csr      (csr_ff),
      .scaled   (scaled)
   );

   psdm_pulse_gen u_pulse_gen (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v3_ff),
      .info         (info3_ff),
      .scaled       (scaled),
      .csr          (csr_ff),
      .rsp_stall    (rsp_stall),
      .out_ready    (out_ready),
      .rsp_valid_ff (rsp_valid),
      .rsp_word_ff  (rsp_word)
   );

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted word lost before first stage");

endmodule
`default_nettype wire

>>> tb/sv/tb_pwm_sine_duty_modulator_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for the sine duty pwm modulator: directed rows, table fill, random phases
module tb_pwm_sine_duty_modulator_unit;
   import psdm_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam longint DUTY_MAP_SPAN = 255;
   localparam int SETTLE_CYCLES = 8;
   localparam int PLAN_ROWS = 20;
   localparam int PHASES = 10;
   localparam int MAX_REPORTS = 10;
   localparam count_type COUNT_MAX = '1;
   localparam rsp_word_type PIN_HIGH_POS0 = '{pulse_out: 1'b1, wave_position: 8'd0};

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_mode_type;

   typedef struct {
      logic          is_csr;
      csr_index_type reg_sel;
      count_type     reg_data;
      req_word_type  word;
      logic          typed;
      rsp_word_type  typed_rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   count_type csr_data = '0;

   csr_set_type pwm_regs;
   count_type period_count;
   count_type duty_count;
   count_type mod_divider;
   logic duty_done;
   logic pin_level;
   field_type wave_index;
   field_type sine_table [TABLE_DEPTH];

   rsp_word_type expected_levels [$];
   stim_row_type stim_plan [PLAN_ROWS];
   int mismatch_count = 0;
   bit reg_burst = 1'b0;
   int burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int stall_left = 0;

   pwm_sine_duty_modulator_unit #(
      .TABLE_SIZE(TABLE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   function automatic count_type sine_duty(field_type entry);
      longint span;
      longint scaled;
      span = longint'(pwm_regs.max_duty_ticks) - longint'(pwm_regs.min_duty_ticks);
      scaled = longint'(entry) * span / DUTY_MAP_SPAN + longint'(pwm_regs.min_duty_ticks);
      return count_type'(scaled);
   endfunction

   function automatic rsp_word_type advance_pwm(req_word_type w);
      if (w.operation == OP_TABLE_WRITE) begin
         sine_table[w.table_index] = w.table_value;
      end else begin
         if (period_count == pwm_regs.period_ticks) begin
            if (w.running) begin
               pin_level = 1'b1;
            end
            if (pwm_regs.mod_enable) begin
               duty_count = sine_duty(sine_table[wave_index]);
            end else begin
               duty_count = pwm_regs.duty_ticks;
            end
            duty_done = 1'b0;
         end
         if (pwm_regs.mod_enable) begin
            if (mod_divider <= 1) begin
               wave_index = wave_index + 8'd1;
               mod_divider = pwm_regs.mod_step_ticks;
            end else begin
               mod_divider = mod_divider - count_type'(1);
            end
         end
         if (!duty_done) begin
            if (duty_count == 0) begin
               pin_level = 1'b0;
               duty_done = 1'b1;
            end else begin
               duty_count = duty_count - count_type'(1);
            end
         end
         if (period_count <= 1) begin
            period_count = pwm_regs.period_ticks;
         end else begin
            period_count = period_count - count_type'(1);
         end
      end
      return '{pulse_out: pin_level, wave_position: wave_index};
   endfunction

   function automatic stim_row_type item_row(logic op, logic run, field_type idx,
                                             field_type val, logic typed, rsp_word_type exp_w);
      stim_row_type r;
      r.is_csr = 1'b0;
      r.reg_sel = REG_PERIOD;
      r.reg_data = '0;
      r.word = '{operation: op, running: run, table_index: idx, table_value: val};
      r.typed = typed;
      r.typed_rsp = exp_w;
      return r;
   endfunction

   function automatic stim_row_type csr_row(csr_index_type sel, count_type val);
      stim_row_type r;
      r.is_csr = 1'b1;
      r.reg_sel = sel;
      r.reg_data = val;
      r.word = '0;
      r.typed = 1'b0;
      r.typed_rsp = '0;
      return r;
   endfunction

   function automatic count_type pick_duty_edge();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return COUNT_MAX;
         default: return count_type'($urandom_range(0, 60));
      endcase
   endfunction

   function automatic csr_set_type random_settings();
      csr_set_type s;
      s.period_ticks = count_type'($urandom_range(0, 40));
      s.duty_ticks = ($urandom_range(0, 7) == 0) ? COUNT_MAX : count_type'($urandom_range(0, 45));
      s.mod_enable = 1'($urandom_range(0, 1));
      s.min_duty_ticks = pick_duty_edge();
      s.max_duty_ticks = pick_duty_edge();
      s.mod_step_ticks = count_type'($urandom_range(0, 5));
      return s;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      w.operation = ($urandom_range(0, 9) == 0) ? OP_TABLE_WRITE : OP_TICK;
      w.running = ($urandom_range(0, 3) != 0);
      w.table_index = field_type'($urandom);
      w.table_value = field_type'($urandom);
      return w;
   endfunction

   task automatic flag_error(input string text);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s", $time, text);
      end
   endtask

   task automatic settle_block();
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type sel, input count_type val);
      if (!reg_burst) begin
         settle_block();
      end
      reg_burst = 1'b1;
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (sel)
         REG_PERIOD: pwm_regs.period_ticks = val;
         REG_DUTY: pwm_regs.duty_ticks = val;
         REG_MOD_ENABLE: pwm_regs.mod_enable = val[0];
         REG_MIN_DUTY: pwm_regs.min_duty_ticks = val;
         REG_MAX_DUTY: pwm_regs.max_duty_ticks = val;
         REG_MOD_STEP: pwm_regs.mod_step_ticks = val;
         default: ;
      endcase
   endtask

   task automatic send_word(input req_word_type w, input logic typed,
                            input rsp_word_type typed_rsp);
      rsp_word_type predicted;
      int gap;
      if (reg_burst) begin
         csr_valid <= 1'b0;
         reg_burst = 1'b0;
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      predicted = advance_pwm(w);
      expected_levels.push_back(typed ? typed_rsp : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin : check_levels
      rsp_word_type exp_w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               flag_error($sformatf("unexpected word pulse_out=%0b wave_position=%0d",
                                    rsp_word.pulse_out, rsp_word.wave_position));
            end else begin
               exp_w = expected_levels.pop_front();
               if (rsp_word.pulse_out !== exp_w.pulse_out) begin
                  flag_error($sformatf("pulse_out expected %0b got %0b",
                                       exp_w.pulse_out, rsp_word.pulse_out));
               end
               if (rsp_word.wave_position !== exp_w.wave_position) begin
                  flag_error($sformatf("wave_position expected %0d got %0d",
                                       exp_w.wave_position, rsp_word.wave_position));
               end
            end
         end
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 200);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 20);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 70);
            default: rsp_stall <= stall_left[0];
         endcase
      end
   end

   initial begin
      #(5_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : run_stimulus
      csr_set_type s;
      req_word_type w;
      count_type en_data;
      int phase_items;

      pwm_regs = '{period_ticks: PERIOD_RESET, duty_ticks: DUTY_RESET,
                   mod_enable: MOD_EN_RESET, min_duty_ticks: MIN_DUTY_RESET,
                   max_duty_ticks: MAX_DUTY_RESET, mod_step_ticks: MOD_STEP_RESET};
      period_count = PERIOD_RESET;
      duty_count = DUTY_RESET;
      mod_divider = MOD_STEP_RESET;
      duty_done = 1'b0;
      pin_level = 1'b0;
      wave_index = '0;

      stim_plan[0] = item_row(OP_TICK, 1'b1, 8'd0, 8'd0, 1'b1, PIN_HIGH_POS0);
      stim_plan[1] = item_row(OP_TICK, 1'b0, 8'd255, 8'd255, 1'b1, PIN_HIGH_POS0);
      stim_plan[2] = item_row(OP_TABLE_WRITE, 1'b0, 8'd0, 8'd0, 1'b1, PIN_HIGH_POS0);
      stim_plan[3] = item_row(OP_TABLE_WRITE, 1'b1, 8'd255, 8'd255, 1'b1, PIN_HIGH_POS0);
      stim_plan[4] = item_row(OP_TABLE_WRITE, 1'b1, 8'd1, 8'd255, 1'b0, '0);
      stim_plan[5] = item_row(OP_TABLE_WRITE, 1'b0, 8'd128, 8'd128, 1'b0, '0);
      stim_plan[6] = csr_row(REG_PERIOD, 24'd3);
      stim_plan[7] = csr_row(REG_DUTY, '0);
      stim_plan[8] = csr_row(REG_MOD_STEP, '0);
      stim_plan[9] = csr_row(REG_MOD_ENABLE, 24'd1);
      stim_plan[10] = item_row(OP_TICK, 1'b1, 8'd0, 8'd0, 1'b0, '0);
      stim_plan[11] = item_row(OP_TICK, 1'b0, 8'd0, 8'd0, 1'b0, '0);
      stim_plan[12] = item_row(OP_TICK, 1'b1, 8'd170, 8'd85, 1'b0, '0);
      stim_plan[13] = csr_row(REG_MOD_STEP, 24'd1);
      stim_plan[14] = item_row(OP_TICK, 1'b1, 8'd0, 8'd0, 1'b0, '0);
      stim_plan[15] = csr_row(REG_MOD_ENABLE, '0);
      stim_plan[16] = csr_row(REG_MIN_DUTY, COUNT_MAX);
      stim_plan[17] = csr_row(REG_MAX_DUTY, '0);
      stim_plan[18] = item_row(OP_TICK, 1'b0, 8'd0, 8'd0, 1'b0, '0);
      stim_plan[19] = item_row(OP_TABLE_WRITE, 1'b1, 8'd127, 8'd0, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_plan[i]) begin
         if (stim_plan[i].is_csr) begin
            write_reg(stim_plan[i].reg_sel, stim_plan[i].reg_data);
         end else begin
            send_word(stim_plan[i].word, stim_plan[i].typed, stim_plan[i].typed_rsp);
         end
      end

      // every table entry is written before the phases below read the table
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         w.operation = OP_TABLE_WRITE;
         w.running = 1'($urandom_range(0, 1));
         w.table_index = field_type'(i);
         w.table_value = field_type'($urandom);
         send_word(w, 1'b0, '0);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: s = '{period_ticks: 24'd7, duty_ticks: 24'd3, mod_enable: 1'b1,
                     min_duty_ticks: 24'd2, max_duty_ticks: 24'd9, mod_step_ticks: 24'd2};
            1: s = '{period_ticks: '0, duty_ticks: '0, mod_enable: 1'b0,
                     min_duty_ticks: '0, max_duty_ticks: COUNT_MAX, mod_step_ticks: 24'd1};
            2: s = '{period_ticks: 24'd1, duty_ticks: 24'd5, mod_enable: 1'b1,
                     min_duty_ticks: '0, max_duty_ticks: COUNT_MAX, mod_step_ticks: '0};
            3: s = '{period_ticks: 24'd12, duty_ticks: '0, mod_enable: 1'b1,
                     min_duty_ticks: 24'd30, max_duty_ticks: 24'd3, mod_step_ticks: 24'd3};
            PHASES - 1: s = '{period_ticks: COUNT_MAX, duty_ticks: COUNT_MAX, mod_enable: 1'b1,
                              min_duty_ticks: COUNT_MAX, max_duty_ticks: COUNT_MAX,
                              mod_step_ticks: COUNT_MAX};
            default: s = random_settings();
         endcase
         en_data = count_type'($urandom);
         en_data[0] = s.mod_enable;
         write_reg(REG_PERIOD, s.period_ticks);
         write_reg(REG_DUTY, s.duty_ticks);
         write_reg(REG_MOD_ENABLE, en_data);
         write_reg(REG_MIN_DUTY, s.min_duty_ticks);
         write_reg(REG_MAX_DUTY, s.max_duty_ticks);
         write_reg(REG_MOD_STEP, s.mod_step_ticks);
         // the first phase sends more words than the later phases
         phase_items = (phase == 0) ? 1000 : 80;
         repeat (phase_items) send_word(random_word(), 1'b0, '0);
      end

      settle_block();
      if (mismatch_count == 0 && expected_levels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
